>>> rtl/core/hpsp_pkg.sv
`default_nettype none
package hpsp_pkg;

	// Longest string length tracked; position saturates here
	localparam int MAX_LEN = 255;
	localparam int POS_W   = $clog2(MAX_LEN + 1);
	localparam int LEN_W   = 8;
	localparam int ACC_W   = 32;
	localparam int PORT_W  = 32;

	localparam logic [ACC_W-1:0] ACC_CAP  = 32'h8000_0000;
	localparam logic [PORT_W-1:0] PORT_MAX = 32'h7FFF_FFFF;

	// Characters with a meaning to the parser
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic signed [2:0] DOT_SKIP_INIT = -3'sd3;

	typedef enum logic [2:0] {
		PH_START,
		PH_BR_ADDR,
		PH_BR_CLOSED,
		PH_DOT_ADDR,
		PH_ERR,
		PH_LEAD,
		PH_SIGN,
		PH_DIG
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} chr_t;

	typedef struct packed {
		logic signed [PORT_W-1:0] port;
		logic                     rewritten;
		logic                     addr_offset;
		logic [LEN_W-1:0]         addr_length;
	} res_t;

	// Per-string parser state
	typedef struct packed {
		phase_t             phase;
		logic               bracket;
		logic [POS_W-1:0]   position;
		logic signed [2:0]  dot_skip;
		logic [POS_W-1:0]   split_pos;
		logic [ACC_W-1:0]   accum;
		logic               negative;
		logic               started;
	} state_t;

	localparam state_t ST_RESET = '{
		phase:     PH_START,
		bracket:   1'b0,
		position:  '0,
		dot_skip:  DOT_SKIP_INIT,
		split_pos: '0,
		accum:     '0,
		negative:  1'b0,
		started:   1'b0
	};

endpackage
`default_nettype wire

>>> rtl/core/hpsp_acc.sv
`default_nettype none
module hpsp_acc import hpsp_pkg::*; (
	input  logic [ACC_W-1:0] acc,
	input  logic [3:0]       digit,
	output logic [ACC_W-1:0] acc_next
);

	logic [ACC_W+2:0] prod;

	// acc * 10 + digit as shift-add, then clamp at 2^31
	always_comb begin
		prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + (ACC_W+3)'(digit);
		if (prod > (ACC_W+3)'(ACC_CAP)) begin
			acc_next = ACC_CAP;
		end else begin
			acc_next = prod[ACC_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/hpsp_step.sv
`default_nettype none
module hpsp_step import hpsp_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] ch,
	output state_t     nxt,
	output res_t       res
);

	logic             is_space;
	logic             is_digit;
	logic             is_sign;
	logic [ACC_W-1:0] acc_dig;
	logic             ok;
	logic             brk;

	assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

	hpsp_acc u_acc (
		.acc      (cur.accum),
		.digit    (ch[3:0]),
		.acc_next (acc_dig)
	);

	// Next state for one character
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_START, PH_DOT_ADDR: begin
				if (cur.phase == PH_START && ch == CH_LBRACK) begin
					nxt.phase = PH_BR_ADDR;
				end else begin
					nxt.phase = PH_DOT_ADDR;
					// colon rearms the dot split; dots count up to it
					if (ch == CH_COLON) begin
						nxt.dot_skip = '0;
					end else if (ch == CH_DOT) begin
						if (!cur.dot_skip[2]) begin
							nxt.split_pos = cur.position;
							nxt.phase     = PH_LEAD;
						end else begin
							nxt.dot_skip = cur.dot_skip + 3'sd1;
						end
					end
				end
			end
			PH_BR_ADDR: begin
				if (ch == CH_RBRACK) begin
					nxt.split_pos = cur.position;
					nxt.phase     = PH_BR_CLOSED;
				end
			end
			PH_BR_CLOSED: begin
				if (ch == CH_COLON) begin
					nxt.phase   = PH_LEAD;
					nxt.bracket = 1'b1;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_LEAD: begin
				nxt.started = 1'b1;
				if (is_space) begin
					nxt.phase = PH_LEAD;
				end else if (is_sign) begin
					nxt.negative = (ch == CH_MINUS);
					nxt.phase    = PH_SIGN;
				end else if (is_digit) begin
					nxt.accum = acc_dig;
					nxt.phase = PH_DIG;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			PH_SIGN, PH_DIG: begin
				if (is_digit) begin
					nxt.accum = acc_dig;
					nxt.phase = PH_DIG;
				end else begin
					nxt.phase = PH_ERR;
				end
			end
			default: begin
				nxt.phase = PH_ERR;
			end
		endcase
		if (cur.position < POS_W'(MAX_LEN)) begin
			nxt.position = cur.position + POS_W'(1);
		end
	end

	// Result as it would stand if this character is the last one
	always_comb begin
		ok  = (nxt.phase == PH_BR_CLOSED) || (nxt.phase == PH_DIG) ||
		      (nxt.phase == PH_LEAD && !nxt.started);
		brk = (nxt.phase == PH_BR_CLOSED) || nxt.bracket;
		res.port        = '0;
		res.rewritten   = ok;
		res.addr_offset = ok && brk;
		if (!ok) begin
			res.addr_length = LEN_W'(cur.position) + LEN_W'(1);
		end else if (brk) begin
			res.addr_length = LEN_W'(nxt.split_pos) - LEN_W'(1);
		end else begin
			res.addr_length = LEN_W'(nxt.split_pos);
		end
		if (ok && nxt.phase == PH_DIG) begin
			if (nxt.negative) begin
				res.port = ~nxt.accum + PORT_W'(1);
			end else if (nxt.accum[ACC_W-1]) begin
				res.port = PORT_MAX;
			end else begin
				res.port = nxt.accum;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/host_port_suffix_parser.sv
// Channel | Dir | Payload | Handshake
// chr     | in  | chr_t   | chr_valid / chr_stall
// res     | out | res_t   | res_valid / res_stall
//
// One character per cycle unless stalled; each character is parsed in a
// single pass of the next-state logic between input and state/result registers.
// A last character's result is registered when it leaves the input register.
// arst_n clears the handshake flags and returns the parser to its start state.
// chr_stall rises only while a last character waits in the input register and
// the result register is full and stalled.
`default_nettype none
module host_port_suffix_parser import hpsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic   valid_s1;
	chr_t   data_s1;
	state_t st_q;
	state_t st_next;
	res_t   res_next;
	res_t   res_q;
	logic   res_valid_q;
	logic   consume;
	logic   load_s1;

	// A buffered character moves on unless it needs a busy result slot
	assign consume   = valid_s1 && (!data_s1.last || !res_valid_q || !res_stall);
	assign load_s1   = !valid_s1 || consume;
	assign chr_stall = !load_s1;

	hpsp_step u_step (
		.cur (st_q),
		.ch  (data_s1.ch),
		.nxt (st_next),
		.res (res_next)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && chr_valid) begin
			data_s1 <= chr;
		end
	end

	// Parser state; restarts after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (consume) begin
			st_q <= data_s1.last ? ST_RESET : st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (consume && data_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && data_s1.last) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

>>> rtl/core/hpsp_checker.sv
`default_nettype none
module hpsp_checker import hpsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic chr_valid,
	input logic chr_stall,
	input chr_t chr,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// A stalled character holds until transferred
	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_stall |=> chr_valid && $stable(chr))
		else $error("character changed while stalled");

	// A stalled result holds until transferred
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// No result while in reset
	a_res_reset: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A failed parse reports port zero and no offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.rewritten |-> res.port == '0 && !res.addr_offset)
		else $error("unrewritten result carries port or offset");

	// A bracket offset only comes with a rewrite
	a_offset_rw: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.addr_offset |-> res.rewritten)
		else $error("offset without rewrite");

endmodule

bind host_port_suffix_parser hpsp_checker u_hpsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.chr_valid (chr_valid),
	.chr_stall (chr_stall),
	.chr       (chr),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import hpsp_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b1;
	logic chr_valid = 1'b0;
	logic chr_stall;
	chr_t chr       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	host_port_suffix_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Idle rates, in percent of cycles
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	int error_count     = 0;
	int chars_sent      = 0;
	int results_checked = 0;

	// Parse results predicted but not yet seen on the result port
	res_t pending_q[$];
	// Characters of the string being built
	logic [7:0] text_q[$];

	// Shadow parser state
	phase_t      scan_phase;
	logic        in_bracket;
	int          char_pos;
	int          dot_credit;
	int          split_at;
	logic [35:0] port_mag;
	logic        port_neg;
	logic        port_seen;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void reset_scan();
		scan_phase = PH_START;
		in_bracket = 1'b0;
		char_pos   = 0;
		dot_credit = -3;
		split_at   = 0;
		port_mag   = '0;
		port_neg   = 1'b0;
		port_seen  = 1'b0;
	endfunction

	// Dot form: a colon re-arms the split, the first dot once armed splits
	function automatic void dot_step(input logic [7:0] c);
		if (c == CH_COLON) begin
			dot_credit = 0;
		end else if (c == CH_DOT) begin
			if (dot_credit >= 0) begin
				split_at   = char_pos;
				scan_phase = PH_LEAD;
			end else begin
				dot_credit++;
			end
		end
	endfunction

	// Decimal accumulate, clamped at 2^31
	function automatic void add_digit(input logic [7:0] c);
		port_mag = port_mag * 10 + (c - CH_ZERO);
		if (port_mag > ACC_CAP)
			port_mag = ACC_CAP;
	endfunction

	// Advance the shadow parser by one character; 1 when a result is due
	function automatic bit parse_char(input logic [7:0] c, input logic fin, output res_t r);
		int total;
		bit ok;
		bit brk;
		bit digit;
		ok    = 1'b0;
		brk   = 1'b0;
		r     = '0;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (scan_phase)
			PH_START: begin
				if (c == CH_LBRACK) begin
					scan_phase = PH_BR_ADDR;
				end else begin
					scan_phase = PH_DOT_ADDR;
					dot_step(c);
				end
			end
			PH_BR_ADDR: begin
				if (c == CH_RBRACK) begin
					split_at   = char_pos;
					scan_phase = PH_BR_CLOSED;
				end
			end
			PH_BR_CLOSED: begin
				if (c == CH_COLON) begin
					scan_phase = PH_LEAD;
					in_bracket = 1'b1;
				end else begin
					scan_phase = PH_ERR;
				end
			end
			PH_DOT_ADDR: dot_step(c);
			PH_LEAD: begin
				port_seen = 1'b1;
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					scan_phase = PH_LEAD;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					port_neg   = (c == CH_MINUS);
					scan_phase = PH_SIGN;
				end else if (digit) begin
					add_digit(c);
					scan_phase = PH_DIG;
				end else begin
					scan_phase = PH_ERR;
				end
			end
			PH_SIGN, PH_DIG: begin
				if (digit) begin
					add_digit(c);
					scan_phase = PH_DIG;
				end else begin
					scan_phase = PH_ERR;
				end
			end
			default: scan_phase = PH_ERR;
		endcase

		total = char_pos + 1;
		if (char_pos < MAX_LEN)
			char_pos++;
		if (!fin)
			return 1'b0;

		if (scan_phase == PH_BR_CLOSED) begin
			ok  = 1'b1;
			brk = 1'b1;
		end else if ((scan_phase == PH_LEAD && !port_seen) || scan_phase == PH_DIG) begin
			ok  = 1'b1;
			brk = in_bracket;
		end

		if (ok) begin
			if (scan_phase == PH_DIG) begin
				if (port_neg)
					r.port = 32'd0 - port_mag[31:0];
				else
					r.port = (port_mag > PORT_MAX) ? PORT_MAX : port_mag[31:0];
			end
			r.rewritten   = 1'b1;
			r.addr_offset = brk;
			r.addr_length = brk ? 8'(split_at - 1) : 8'(split_at);
		end else begin
			r.addr_length = 8'(total);
		end
		reset_scan();
		return 1'b1;
	endfunction

	// One character transfer, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic fin);
		res_t r;
		while ($urandom_range(99) < gap_pct) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr_valid <= 1'b1;
		chr       <= '{ch: c, last: fin};
		@(posedge clk);
		while (chr_stall)
			@(posedge clk);
		if (parse_char(c, fin, r))
			pending_q.push_back(r);
		chars_sent++;
	endtask

	// Send the built string, marking its final character
	task automatic send_text();
		if (text_q.size() == 0)
			text_q.push_back(CH_COLON);
		foreach (text_q[i])
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic wait_drained();
		chr_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// Address character; never a closing bracket
	function automatic logic [7:0] host_char();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1, 2, 3: b = 8'(8'h61 + $urandom_range(25));
			4, 5:       b = 8'(CH_ZERO + $urandom_range(9));
			6:          b = CH_COLON;
			7:          b = CH_DOT;
			default: begin
				do
					b = 8'($urandom_range(255));
				while (b == CH_RBRACK);
			end
		endcase
		return b;
	endfunction

	// Port text: whitespace, sign, digits, now and then junk or a range edge
	function automatic void add_port_text();
		int unsigned pick;
		if ($urandom_range(15) == 0) begin
			case ($urandom_range(4))
				0: push_str("2147483647");
				1: push_str("2147483648");
				2: push_str("-2147483648");
				3: push_str("-2147483649");
				default: push_str("+99999999999");
			endcase
		end else begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					pick = $urandom_range(5);
					text_q.push_back(pick == 5 ? CH_SPACE : 8'(CH_TAB + pick));
				end
			end
			pick = $urandom_range(3);
			if (pick == 1)
				text_q.push_back(CH_PLUS);
			else if (pick == 2)
				text_q.push_back(CH_MINUS);
			repeat (($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5))
				text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(9) == 0)
				text_q.push_back(host_char());
		end
	endfunction

	// Bracket form: empty address, and a negative port
	task automatic test_bracket_form();
		push_str("[]");
		send_text();
		push_str("[]:-9");
		send_text();
		wait_drained();
	endtask

	// Dot form: split after a colon with no port, and after three skipped dots
	task automatic test_dot_form();
		push_str("a:.");
		send_text();
		push_str("....");
		send_text();
		wait_drained();
	endtask

	// Missing close bracket, sign-only and whitespace-only port text
	task automatic test_bad_port_text();
		push_str("[a");
		send_text();
		push_str(":.+");
		send_text();
		push_str(":.\t");
		send_text();
		wait_drained();
	endtask

	// Zero and all-ones characters carry no meaning
	task automatic test_odd_characters();
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		send_text();
		wait_drained();
	endtask

	// Mostly well-formed strings with random content, the rest noise;
	// optionally one string running past the length limit
	task automatic test_random_strings(input int budget, input int unsigned gap,
			input int unsigned stall, input bit with_long);
		int start;
		int long_at;
		int unsigned kind;
		bit brk;
		start     = chars_sent;
		gap_pct   = gap;
		stall_pct = stall;
		long_at   = with_long ? int'($urandom_range(budget - 1)) : -1;
		while (chars_sent - start < budget) begin
			kind = $urandom_range(99);
			if (long_at >= 0 && chars_sent - start >= long_at) begin
				long_at = -1;
				brk = 1'($urandom_range(1));
				text_q.push_back(brk ? CH_LBRACK : CH_COLON);
				repeat ($urandom_range(250, 262))
					text_q.push_back(8'(8'h61 + $urandom_range(25)));
				text_q.push_back(brk ? CH_RBRACK : CH_DOT);
				if (brk)
					text_q.push_back(CH_COLON);
				add_port_text();
			end else if (kind < 35) begin
				text_q.push_back(CH_LBRACK);
				repeat ($urandom_range(0, 6))
					text_q.push_back(host_char());
				if ($urandom_range(15) != 0)
					text_q.push_back(CH_RBRACK);
				if ($urandom_range(3) != 0) begin
					text_q.push_back(CH_COLON);
					add_port_text();
				end
			end else if (kind < 80) begin
				repeat ($urandom_range(0, 5)) begin
					repeat ($urandom_range(0, 3))
						text_q.push_back(host_char());
					text_q.push_back($urandom_range(3) == 0 ? CH_COLON : CH_DOT);
				end
				if ($urandom_range(4) != 0)
					text_q.push_back(CH_DOT);
				add_port_text();
			end else begin
				repeat ($urandom_range(1, 12))
					text_q.push_back(8'($urandom_range(255)));
			end
			send_text();
		end
		wait_drained();
	endtask

	// Check each result transfer against the oldest prediction; drive stall
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing pending: port %0d length %0d",
					res.port, res.addr_length);
				error_count++;
			end else begin
				want = pending_q.pop_front();
				results_checked++;
				if (res.port !== want.port) begin
					$error("port: expected %0d, got %0d", want.port, res.port);
					error_count++;
				end
				if (res.rewritten !== want.rewritten) begin
					$error("rewritten: expected %0d, got %0d", want.rewritten, res.rewritten);
					error_count++;
				end
				if (res.addr_offset !== want.addr_offset) begin
					$error("addr_offset: expected %0d, got %0d",
						want.addr_offset, res.addr_offset);
					error_count++;
				end
				if (res.addr_length !== want.addr_length) begin
					$error("addr_length: expected %0d, got %0d",
						want.addr_length, res.addr_length);
					error_count++;
				end
			end
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		// Falling edge at time zero so the asynchronous reset takes hold at once
		arst_n <= 1'b0;
		reset_scan();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bracket_form();
		test_dot_form();
		test_bad_port_text();
		test_odd_characters();
		test_random_strings(450, 0, 0, 1'b1);
		test_random_strings(450, 83, 0, 1'b0);
		test_random_strings(450, 0, 83, 1'b1);
		test_random_strings(450, 8, 8, 1'b0);

		// Catch any stray result after the last expected one
		repeat (16) @(posedge clk);

		$display("Sent %0d characters, checked %0d parse results: bracket and dot forms,",
			chars_sent, results_checked);
		$display("signed and clamped ports, bad port text, over-length strings, four stall mixes.");
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
